>>> sv/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg: shared types and constants for the vertex normal accumulator
// Opcodes, widths, and the request record that crosses the front/back queue.
// ----------------------------------------------------------------------------
package vna_pkg;

   localparam int VertexCount = 1024;
   localparam int IdxW        = 10;
   localparam int PosW        = 16;
   localparam int SumW        = 40;
   localparam int QueueDepth  = 2;

   localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
   localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_TRI   = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   // classified request passed from front to back
   typedef struct packed {
      opcode_type             op;
      logic                   oob;
      logic [IdxW-1:0]        idx;
      logic signed [PosW-1:0] px;
      logic signed [PosW-1:0] py;
      logic signed [PosW-1:0] pz;
      logic [IdxW-1:0]        ca;
      logic [IdxW-1:0]        cb;
      logic [IdxW-1:0]        cc;
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RDA, ST_RDB, ST_RDC, ST_EDGE, ST_CROSS, ST_FACE,
      ST_UPA, ST_WRA, ST_UPB, ST_WRB, ST_UPC, ST_WRC,
      ST_RSUM, ST_MAG, ST_SHIFT, ST_SQ, ST_LEN,
      ST_DIV, ST_SQRT, ST_NEXT, ST_OUT
   } state_type;

endpackage

>>> sv/vna_front.sv
// ----------------------------------------------------------------------------
// vna_front: request intake
// Accepts requests, classifies opcode and index range, queues all but OP_NONE for the back.
// ----------------------------------------------------------------------------
module vna_front import vna_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [87:0]     req_tdata,
   input  logic [1:0]      req_tuser,
   output logic            q_valid,
   input  logic            q_pop,
   output cmd_type         q_cmd
);
   cmd_type             mem_ff [QueueDepth];
   logic                wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]          cnt_ff, cnt_in;
   cmd_type             cmd;
   logic                push;

   // unpack and classify
   always_comb begin
      cmd.op  = opcode_type'(req_tuser);
      cmd.idx = req_tdata[9:0];
      cmd.px  = req_tdata[25:10];
      cmd.py  = req_tdata[41:26];
      cmd.pz  = req_tdata[57:42];
      cmd.ca  = req_tdata[67:58];
      cmd.cb  = req_tdata[77:68];
      cmd.cc  = req_tdata[87:78];
      unique case (cmd.op)
         OP_TRI:  cmd.oob = (32'(cmd.ca) >= VertexCount) || (32'(cmd.cb) >= VertexCount)
                            || (32'(cmd.cc) >= VertexCount);
         default: cmd.oob = 32'(cmd.idx) >= VertexCount;
      endcase
   end

   assign req_tready = cnt_ff != 2'(QueueDepth);
   assign push       = req_tvalid && req_tready && cmd.op != OP_NONE;
   assign q_valid    = cnt_ff != 2'd0;
   assign q_cmd      = mem_ff[rp_ff];

   // queue pointers
   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ (q_pop && q_valid);
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= cmd;
   end

`ifndef ASSERT_OFF
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QueueDepth)) else $error("queue overflow");
   a_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'(QueueDepth) |-> !req_tready) else $error("ready while full");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      !q_valid |=> cnt_ff <= 2'd1) else $error("count jump");
`endif
endmodule

>>> sv/vna_back.sv
// ----------------------------------------------------------------------------
// vna_back: mesh table sequencer
// Runs writes, triangle accumulation and normalized reads over table memories.
// ----------------------------------------------------------------------------
module vna_back import vna_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   output logic            q_pop,
   input  cmd_type         q_cmd,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [63:0]     rsp_tdata,
   output logic            rsp_tuser
);
   // table memories
   logic [3*PosW-1:0] pos_mem [VertexCount];
   logic [3*SumW-1:0] sum_mem [VertexCount];
   logic [3*PosW-1:0] pos_rd_ff;
   logic [3*SumW-1:0] sum_rd_ff;

   state_type state_ff, state_in;
   cmd_type   cmd_ff;

   logic signed [PosW-1:0] pa_ff [3];
   logic signed [PosW-1:0] pb_ff [3];
   logic signed [PosW:0]   e1_ff [3];
   logic signed [PosW:0]   e2_ff [3];
   logic signed [2*PosW+1:0] pr_ff [6];
   logic signed [SumW-1:0] face_ff [3];
   logic signed [SumW-1:0] s_ff [3];
   logic [SumW-1:0]        m_ff [3];
   logic [15:0]            mm_ff [3];
   logic [31:0]            sq_ff [3];
   logic [33:0]            len_ff;
   logic [1:0]             k_ff;
   // divider / square root
   logic [61:0]            num_ff;
   logic [33:0]            rem_ff;
   logic [31:0]            quo_ff;   // q <= 2^30
   logic [5:0]             it_ff;
   logic [31:0]            srem_ff;
   logic [15:0]            sres_ff;
   logic [15:0]            nrm_ff [3];
   logic                   deg_ff;

   logic [IdxW-1:0] addr;
   logic            pos_we, sum_we;
   logic [3*SumW-1:0] sum_wd;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (q_valid) begin
            if (q_cmd.oob && q_cmd.op == OP_READ) state_in = ST_OUT;
            else if (q_cmd.oob)                   state_in = ST_IDLE;
            else if (q_cmd.op == OP_TRI)          state_in = ST_RDA;
            else if (q_cmd.op == OP_READ)         state_in = ST_RSUM;
            else                                   state_in = ST_IDLE;
         end
         ST_RDA:   state_in = ST_RDB;
         ST_RDB:   state_in = ST_RDC;
         ST_RDC:   state_in = ST_EDGE;
         ST_EDGE:  state_in = ST_CROSS;
         ST_CROSS: state_in = ST_FACE;
         ST_FACE:  state_in = ST_UPA;
         ST_UPA:   state_in = ST_WRA;
         ST_WRA:   state_in = ST_UPB;
         ST_UPB:   state_in = ST_WRB;
         ST_WRB:   state_in = ST_UPC;
         ST_UPC:   state_in = ST_WRC;
         ST_WRC:   state_in = ST_IDLE;
         ST_RSUM:  state_in = ST_MAG;
         ST_MAG:   state_in = ST_SHIFT;
         ST_SHIFT: state_in = (m_ff[0][SumW-1:16] == '0 && m_ff[1][SumW-1:16] == '0
                                && m_ff[2][SumW-1:16] == '0) ? ST_SQ : ST_SHIFT;
         ST_SQ:    state_in = ST_LEN;
         ST_LEN:   state_in = (sq_ff[0] == '0 && sq_ff[1] == '0 && sq_ff[2] == '0)
                              ? ST_OUT : ST_DIV;
         ST_DIV:   state_in = (it_ff == 6'd0) ? ST_SQRT : ST_DIV;
         ST_SQRT:  state_in = (it_ff == 6'd0) ? ST_NEXT : ST_SQRT;
         ST_NEXT:  state_in = (k_ff == 2'd2) ? ST_OUT : ST_DIV;
         ST_OUT:   state_in = rsp_tready ? ST_IDLE : ST_OUT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs / memory controls
   // each update cycle reads the next corner while the write cycle holds it
   always_comb begin
      q_pop  = state_ff == ST_IDLE && q_valid;
      pos_we = q_pop && q_cmd.op == OP_WRITE && !q_cmd.oob;
      sum_we = pos_we || state_ff == ST_WRA || state_ff == ST_WRB || state_ff == ST_WRC;
      sum_wd = pos_we ? '0 : {s_ff[2], s_ff[1], s_ff[0]};
      unique case (state_ff)
         ST_IDLE:          addr = q_cmd.op == OP_TRI ? q_cmd.ca : q_cmd.idx;
         ST_RDA, ST_UPA:   addr = cmd_ff.cb;
         ST_RDB, ST_UPB:   addr = cmd_ff.cc;
         ST_WRB:           addr = cmd_ff.cb;
         ST_WRC:           addr = cmd_ff.cc;
         default:          addr = cmd_ff.ca;
      endcase
      rsp_tvalid = state_ff == ST_OUT;
      rsp_tdata  = {6'd0, nrm_ff[2], nrm_ff[1], nrm_ff[0], cmd_ff.idx};
      rsp_tuser  = deg_ff;
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[addr] <= {q_cmd.pz, q_cmd.py, q_cmd.px};
      if (sum_we) sum_mem[addr] <= sum_wd;
      pos_rd_ff <= pos_mem[addr];
      if (!sum_we) sum_rd_ff <= sum_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      logic signed [SumW:0] t;
      logic [34:0]          r2;
      logic [31:0]          tb;
      if (q_pop) begin
         cmd_ff <= q_cmd; deg_ff <= 1'b1; k_ff <= 2'd0;
         for (int i = 0; i < 3; i++) nrm_ff[i] <= '0;
      end
      unique case (state_ff)
         ST_RDA: for (int i = 0; i < 3; i++) pa_ff[i] <= pos_rd_ff[i*PosW +: PosW];
         ST_RDB: for (int i = 0; i < 3; i++) pb_ff[i] <= pos_rd_ff[i*PosW +: PosW];
         ST_RDC: for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= (PosW+1)'(pb_ff[i]) - (PosW+1)'(pa_ff[i]);
            e2_ff[i] <= (PosW+1)'($signed(pos_rd_ff[i*PosW +: PosW])) - (PosW+1)'(pa_ff[i]);
         end
         ST_EDGE: begin
            pr_ff[0] <= e1_ff[1] * e2_ff[2]; pr_ff[1] <= e1_ff[2] * e2_ff[1];
            pr_ff[2] <= e1_ff[2] * e2_ff[0]; pr_ff[3] <= e1_ff[0] * e2_ff[2];
            pr_ff[4] <= e1_ff[0] * e2_ff[1]; pr_ff[5] <= e1_ff[1] * e2_ff[0];
         end
         ST_CROSS: for (int i = 0; i < 3; i++)
            face_ff[i] <= SumW'(pr_ff[2*i]) - SumW'(pr_ff[2*i+1]);
         ST_UPA, ST_UPB, ST_UPC: for (int i = 0; i < 3; i++) begin
            t = (SumW+1)'($signed(sum_rd_ff[i*SumW +: SumW])) + (SumW+1)'(face_ff[i]);
            if (t > (SumW+1)'(SumMax))      s_ff[i] <= SumMax;
            else if (t < (SumW+1)'(SumMin)) s_ff[i] <= SumMin;
            else                            s_ff[i] <= t[SumW-1:0];
         end
         ST_RSUM: for (int i = 0; i < 3; i++) s_ff[i] <= sum_rd_ff[i*SumW +: SumW];
         ST_MAG: for (int i = 0; i < 3; i++)
            m_ff[i] <= s_ff[i][SumW-1] ? -s_ff[i] : s_ff[i];
         ST_SHIFT: if (state_in == ST_SHIFT) begin
            for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
         end else begin
            for (int i = 0; i < 3; i++) mm_ff[i] <= m_ff[i][15:0];
         end
         ST_SQ: for (int i = 0; i < 3; i++) sq_ff[i] <= mm_ff[i] * mm_ff[i];
         ST_LEN: begin
            len_ff <= 34'(sq_ff[0]) + 34'(sq_ff[1]) + 34'(sq_ff[2]);
            num_ff <= {sq_ff[0], 30'd0}; rem_ff <= '0; it_ff <= 6'd61;
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            r2 = {rem_ff, num_ff[61]};
            num_ff <= num_ff << 1;
            if (r2 >= 35'(len_ff)) begin
               rem_ff <= 34'(r2 - 35'(len_ff)); quo_ff <= {quo_ff[30:0], 1'b1};
            end else begin
               rem_ff <= r2[33:0]; quo_ff <= {quo_ff[30:0], 1'b0};
            end
            if (it_ff == 6'd0) begin
               srem_ff <= '0; sres_ff <= '0; it_ff <= 6'd15;
            end else it_ff <= it_ff - 6'd1;
         end
         ST_SQRT: begin
            // digit-by-digit root over 16 bit pairs
            tb = {srem_ff[29:0], quo_ff[2*it_ff[3:0]+1 -: 2]};
            if (tb >= {14'd0, sres_ff, 2'b01}) begin
               srem_ff <= tb - {14'd0, sres_ff, 2'b01}; sres_ff <= {sres_ff[14:0], 1'b1};
            end else begin
               srem_ff <= tb; sres_ff <= {sres_ff[14:0], 1'b0};
            end
            if (it_ff != 6'd0) it_ff <= it_ff - 6'd1;
         end
         ST_NEXT: begin
            nrm_ff[k_ff] <= s_ff[k_ff][SumW-1] ? -((16'(sres_ff) + 16'd1) >> 1)
                                               : ((16'(sres_ff) + 16'd1) >> 1);
            deg_ff <= 1'b0;
            k_ff   <= k_ff + 2'd1;
            num_ff <= {sq_ff[(k_ff == 2'd0) ? 2'd1 : 2'd2], 30'd0};
            rem_ff <= '0; it_ff <= 6'd61;
         end
         default: ;
      endcase
   end

`ifndef ASSERT_OFF
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("response dropped");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE) else $error("pop while busy");
   a_deg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[57:10] == '0) else $error("degenerate nonzero");
`endif
endmodule

>>> sv/vertex_normal_accumulator_core.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_core: area weighted vertex normals
// Stores mesh positions, accumulates face normals, returns unit normals.
//
//   channel | dir | tdata fields (low bit first)                 | tuser
//   req     | in  | vertex_id, pos_x, pos_y, pos_z, corner_a/b/c | opcode
//   rsp     | out | read_index, normal_x, normal_y, normal_z      | degenerate
//
// Writes and triangles run on single-port position and sum memories. Reads use serial units:
// a magnitude shift pass, then a divide pass and a root pass for each component;
// a zero-length sum skips the divide and root passes.
// Synchronous reset clears control only; memories are valid once written.
// A two-entry queue lets intake continue while the sequencer or rsp stalls.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_core import vna_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,  // vertex_id,pos_x,pos_y,pos_z,corner_a,b,c
   input  logic [1:0]  req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // read_index,normal_x,normal_y,normal_z
   output logic        rsp_tuser   // degenerate
);
   logic    q_valid, q_pop;
   cmd_type q_cmd;

   vna_front u_front (.clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
                      .q_valid, .q_pop, .q_cmd);
   vna_back  u_back  (.clock, .reset, .q_valid, .q_pop, .q_cmd,
                      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser);
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vertex_normal_accumulator_core
// Streams vertex writes, triangle accumulations and normal reads. The bench
// keeps its own copy of the mesh table and the normal sums and predicts every
// read. Both channels idle at random, and each response is checked field by
// field against the oldest pending read.
// ----------------------------------------------------------------------------
module testbench;
   import vna_pkg::*;

   localparam int RandomItems = 1130;
   localparam int IdleLimit   = 20000;
   localparam int DrainCycles = 600;

   typedef struct {
      opcode_type       op;
      logic [IdxW-1:0]  idx;
      logic [PosW-1:0]  px, py, pz;
      logic [IdxW-1:0]  ca, cb, cc;
   } mesh_req_t;

   typedef struct packed {
      logic [IdxW-1:0] idx;
      logic [15:0]     nx, ny, nz;
      logic            degen;
   } normal_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;   // vertex_id,pos_x,pos_y,pos_z,corner_a,b,c
   logic [1:0]  req_tuser = '0;   // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // read_index,normal_x,normal_y,normal_z
   logic        rsp_tuser;        // degenerate

   vertex_normal_accumulator_core u_top (.*);

   always #5 clock = ~clock;

   // predicted state of the mesh table
   longint      mesh_pos[VertexCount][3];
   longint      normal_sum[VertexCount][3];
   mesh_req_t   pending_q[$];
   normal_rsp_t expected_normals[$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;

   function automatic longint sat_sum(longint s, longint d);
      longint r;
      r = s + d;
      if (r > longint'(SumMax)) r = longint'(SumMax);
      if (r < longint'(SumMin)) r = longint'(SumMin);
      return r;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] unit_part(longint s, longint unsigned m,
                                             longint unsigned len2);
      longint unsigned q, r;
      q = ((m * m) << 30) / len2;
      r = (int_sqrt(q) + 1) >> 1;
      if (s < 0) r = -r;
      return r[15:0];
   endfunction

   // apply one accepted request to the predicted table
   task automatic apply_request(mesh_req_t it);
      longint e1[3], e2[3], face[3];
      longint unsigned m[3], mm, len2;
      logic [IdxW-1:0] cn[3];
      normal_rsp_t rsp;
      case (it.op)
         OP_WRITE: begin
            mesh_pos[it.idx][0] = longint'(signed'(it.px));
            mesh_pos[it.idx][1] = longint'(signed'(it.py));
            mesh_pos[it.idx][2] = longint'(signed'(it.pz));
            for (int k = 0; k < 3; k++) normal_sum[it.idx][k] = 0;
         end
         OP_TRI: begin
            cn[0] = it.ca; cn[1] = it.cb; cn[2] = it.cc;
            for (int k = 0; k < 3; k++) begin
               e1[k] = mesh_pos[cn[1]][k] - mesh_pos[cn[0]][k];
               e2[k] = mesh_pos[cn[2]][k] - mesh_pos[cn[0]][k];
            end
            face[0] = e1[1] * e2[2] - e1[2] * e2[1];
            face[1] = e1[2] * e2[0] - e1[0] * e2[2];
            face[2] = e1[0] * e2[1] - e1[1] * e2[0];
            for (int c = 0; c < 3; c++)
               for (int k = 0; k < 3; k++)
                  normal_sum[cn[c]][k] = sat_sum(normal_sum[cn[c]][k], face[k]);
         end
         OP_READ: begin
            rsp.idx = it.idx;
            rsp.nx = '0; rsp.ny = '0; rsp.nz = '0; rsp.degen = 1'b1;
            mm = 0;
            for (int k = 0; k < 3; k++) begin
               m[k] = (normal_sum[it.idx][k] < 0) ? -normal_sum[it.idx][k]
                                                   : normal_sum[it.idx][k];
               if (m[k] > mm) mm = m[k];
            end
            while (mm >= 65536) begin
               mm >>= 1;
               for (int k = 0; k < 3; k++) m[k] >>= 1;
            end
            len2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            if (len2 != 0) begin
               rsp.nx = unit_part(normal_sum[it.idx][0], m[0], len2);
               rsp.ny = unit_part(normal_sum[it.idx][1], m[1], len2);
               rsp.nz = unit_part(normal_sum[it.idx][2], m[2], len2);
               rsp.degen = 1'b0;
            end
            expected_normals.insert(expected_normals.size(), rsp);
         end
         default: ;  // unused opcode is dropped
      endcase
   endtask

   function automatic logic [87:0] pack_request(mesh_req_t it);
      return {it.cc, it.cb, it.ca, it.pz, it.py, it.px, it.idx};
   endfunction

   // request driver: bursts of random length separated by random gaps
   mesh_req_t cur_req;
   int        burst_left = 0;
   int        gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_request(cur_req);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               cur_req = pending_q.pop_front();
               req_tdata <= pack_request(cur_req);
               req_tuser <= cur_req.op;
               req_tvalid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 16);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with its own stall pattern
   int stall_phase = 0;
   normal_rsp_t got, exp_rsp;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase[9:8] == 2'd0) rsp_tready <= 1'b1;
         else if (stall_phase[9:8] == 2'd1) rsp_tready <= ($urandom_range(0, 3) != 0);
         else rsp_tready <= ($urandom_range(0, 2) == 0);
         if (rsp_tvalid && rsp_tready) begin
            got.idx = rsp_tdata[9:0];
            got.nx = rsp_tdata[25:10];
            got.ny = rsp_tdata[41:26];
            got.nz = rsp_tdata[57:42];
            got.degen = rsp_tuser;
            if (expected_normals.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: idx=%0d n=(%0d,%0d,%0d) degen=%0b",
                           got.idx, $signed(got.nx), $signed(got.ny),
                           $signed(got.nz), got.degen);
            end else begin
               exp_rsp = expected_normals.pop_front();
               if (got != exp_rsp) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: exp idx=%0d n=(%0d,%0d,%0d) d=%0b",
                               " | got idx=%0d n=(%0d,%0d,%0d) d=%0b"},
                              exp_rsp.idx, $signed(exp_rsp.nx), $signed(exp_rsp.ny),
                              $signed(exp_rsp.nz), exp_rsp.degen, got.idx,
                              $signed(got.nx), $signed(got.ny), $signed(got.nz),
                              got.degen);
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("[vertex_normal_accumulator_core] ERROR");
         $finish;
      end
   end

   // vertex pool, all written before first use
   int unsigned vertex_pool[$] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13,
                                   255, 512, 1023};

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic mesh_req_t make_req(opcode_type op, int unsigned idx,
                                          int unsigned a, int unsigned b,
                                          int unsigned c);
      mesh_req_t r;
      r.op = op; r.idx = IdxW'(idx);
      r.px = PosW'($urandom()); r.py = PosW'($urandom()); r.pz = PosW'($urandom());
      r.ca = IdxW'(a); r.cb = IdxW'(b); r.cc = IdxW'(c);
      return r;
   endfunction

   function automatic int unsigned pick_vertex();
      return vertex_pool[$urandom_range(0, vertex_pool.size() - 1)];
   endfunction

   mesh_req_t it;
   int unsigned sel;

   initial begin
      // directed part: extreme positions on the pool, then each opcode
      foreach (vertex_pool[i]) begin
         it = make_req(OP_WRITE, vertex_pool[i], $urandom(), $urandom(), $urandom());
         it.px = (i % 2) ? 16'h7fff : 16'h8000;
         it.py = (i % 3 == 0) ? 16'h8000 : 16'h7fff;
         it.pz = (i % 4 < 2) ? 16'h0000 : 16'h8000;
         pending_q.insert(pending_q.size(), it);
      end
      pending_q.insert(pending_q.size(),
                       make_req(OP_READ, 0, $urandom(), $urandom(), $urandom()));
      pending_q.insert(pending_q.size(), make_req(OP_TRI, $urandom(), 0, 1, 2));
      pending_q.insert(pending_q.size(), make_req(OP_TRI, $urandom(), 1023, 512, 255));
      pending_q.insert(pending_q.size(),
                       make_req(OP_TRI, $urandom(), 3, 3, 4));   // repeated corner
      pending_q.insert(pending_q.size(), make_req(OP_NONE, 1023, 1023, 1023, 255));
      pending_q.insert(pending_q.size(),
                       make_req(OP_READ, 1023, $urandom(), $urandom(), $urandom()));
      pending_q.insert(pending_q.size(),
                       make_req(OP_READ, 3, $urandom(), $urandom(), $urandom()));

      // random part: mostly triangles and reads over written vertices
      for (int n = 0; n < RandomItems; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 14) begin
            it = make_req(OP_WRITE, pick_vertex(), 0, 0, 0);
            it.px = rand_coord(); it.py = rand_coord(); it.pz = rand_coord();
         end else if (sel < 64) begin
            it = make_req(OP_TRI, $urandom(), pick_vertex(), pick_vertex(), pick_vertex());
            if ($urandom_range(0, 9) == 0) it.cb = it.ca;
         end else if (sel < 96) begin
            it = make_req(OP_READ, pick_vertex(), $urandom(), $urandom(), $urandom());
         end else begin
            it = make_req(OP_NONE, $urandom(), $urandom(), $urandom(), $urandom());
         end
         pending_q.insert(pending_q.size(), it);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_normals.size() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_normals.size() == 0)
         $display("[vertex_normal_accumulator_core] OK");
      else
         $display("[vertex_normal_accumulator_core] ERROR");
      $finish;
   end

endmodule

>>> files.f
sv/vna_pkg.sv
sv/vna_front.sv
sv/vna_back.sv
sv/vertex_normal_accumulator_core.sv
tb/testbench.sv
